// ----- design/ccf_pkg.sv -----
// ----------------------------------------------------------------------------
// Calorimeter cluster finder package
// Shared payload types, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package ccf_pkg;

    // Fixed field widths of the ports.
    localparam int IN_E_W   = 16;
    localparam int THR_W    = 16;
    localparam int CLU_E_W  = 27;
    localparam int POS_W    = 12;
    localparam int ID_W     = 11;
    localparam int QUO_W    = 13;
    localparam int CFG_IDX_W = 1;

    // Centroid saturation limits.
    localparam logic [QUO_W-1:0] POS_MAX     = 13'd2047;
    localparam logic [QUO_W-1:0] NEG_MAG_MAX = 13'd2048;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SEED_THR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 1'b1;

    typedef struct packed {
        logic [IN_E_W-1:0] crystal_energy;
        logic              frame_last;
    } t_crystal_in;

    typedef struct packed {
        logic                    cluster_valid;
        logic [CLU_E_W-1:0]      cluster_energy;
        logic signed [POS_W-1:0] x_position;
        logic signed [POS_W-1:0] y_position;
        logic [ID_W-1:0]         seed_index;
        logic [ID_W-1:0]         member_total;
        logic                    overflow_flag;
        logic                    last_result;
    } t_cluster_out;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CLEAR,
        S_SCAN,
        S_SCAN_CHK,
        S_POP,
        S_POP_WAIT,
        S_ADD,
        S_NB,
        S_NB_CHK,
        S_DIV_X,
        S_DIV_Y,
        S_NEXT,
        S_EMPTY,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WT
    } t_state;

endpackage

// ----- design/ccf_divider.sv -----
// ----------------------------------------------------------------------------
// Centroid divider
// Restoring divider that turns a moment and an energy sum into a rounded,
// saturated position in 1/16 mm, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccf_divider
    import ccf_pkg::*;
#(
    parameter int MOM_W = 33,
    parameter int SUM_W = 27
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [MOM_W-1:0] i_moment,
    input  logic [SUM_W-1:0]        i_sum,
    output logic                    o_done,
    output logic signed [POS_W-1:0] o_pos
);

    localparam int DIV_W  = MOM_W + 14;
    localparam int STEP_W = $clog2(QUO_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_div;
    logic [QUO_W-1:0]   r_q;
    logic               r_neg;

    logic [MOM_W-1:0]   mag;
    logic [QUO_W-1:0]   q_pos;
    logic [QUO_W-1:0]   q_neg;
    logic [QUO_W-1:0]   q_neg_n;

    // Magnitude of the incoming moment.
    always_comb begin
        if (i_moment < 0) begin
            mag = MOM_W'(-i_moment);
        end else begin
            mag = MOM_W'(i_moment);
        end
    end

    // Quotient bits, largest first: the numerator is 160*|m| + sum and the
    // divisor 2*sum, which gives round half away from zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_step <= '0;
                r_neg  <= (i_moment < 0);
                r_q    <= '0;
                r_rem  <= (DIV_W'(mag) << 7) + (DIV_W'(mag) << 5) + DIV_W'(i_sum);
                r_div  <= DIV_W'(i_sum) << QUO_W;
            end else if (r_busy) begin
                if (r_rem >= r_div) begin
                    r_rem <= r_rem - r_div;
                    r_q   <= {r_q[QUO_W-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[QUO_W-2:0], 1'b0};
                end
                r_div  <= r_div >> 1;
                r_step <= r_step + 1'b1;
                r_done <= (r_step == LAST_STEP);
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    // Saturate to the signed 12-bit range.
    always_comb begin
        q_pos   = (r_q > POS_MAX) ? POS_MAX : r_q;
        q_neg   = (r_q > NEG_MAG_MAX) ? NEG_MAG_MAX : r_q;
        q_neg_n = QUO_W'(-q_neg);
        if (r_neg) begin
            o_pos = q_neg_n[POS_W-1:0];
        end else begin
            o_pos = q_pos[POS_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

// ----- design/calorimeter_cluster_finder_unit.sv -----
// ----------------------------------------------------------------------------
// Calorimeter cluster finder
// Loads a frame of crystal energies and reports 8-connected clusters.
// ----------------------------------------------------------------------------
// Usage: crystal beats arrive on i_in / i_in_valid / o_in_ready in ID order,
// one per cycle while loading. The beat with frame_last set starts the
// clustering pass and o_in_ready drops until every result of the frame has
// been taken on o_out. Thresholds are written on the i_cfg_* channel, which
// is always ready; write them only while the block is idle.
// After frame_last the sequencer clears the visited marks, then tests each
// crystal ID as a seed; each cluster member is popped from the search stack
// and added, then the in-grid places of its 3x3 neighbourhood are checked
// and the off-grid ones skipped. A cluster closes when the stack is empty,
// and each reported cluster goes through the shared centroid divider (13
// steps per axis). Results are buffered and sent one at a time, so a held
// i_out_ready simply stalls the sequencer; the beat stays on o_out.
// An empty frame gives one beat with cluster_valid clear and last_result set.
// Reset returns the thresholds to 800 and 8 and the block to loading at
// crystal ID zero; the energy store holds no defined value until loaded.
// ----------------------------------------------------------------------------
module calorimeter_cluster_finder_unit
    import ccf_pkg::*;
#(
    parameter int GRID_SIDE    = 35,
    parameter int ENERGY_BITS  = 16,
    parameter int MAX_CLUSTERS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_crystal_in          i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_cluster_out         o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [THR_W-1:0]     i_cfg_data
);

    localparam int CELLS   = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W  = $clog2(CELLS);
    localparam int ROW_W   = $clog2(GRID_SIDE);
    localparam int COORD_W = ROW_W + 1;
    localparam int SUM_W   = ENERGY_BITS + $clog2(CELLS + 1);
    localparam int MOM_W   = SUM_W + COORD_W;
    localparam int CMP_W   = (ENERGY_BITS > THR_W) ? ENERGY_BITS : THR_W;
    localparam int CLU_W   = $clog2(MAX_CLUSTERS + 1);
    localparam int BUF_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int HALF    = GRID_SIDE / 2;
    localparam logic [CELL_W:0]   CELLS_C = (CELL_W + 1)'(CELLS);
    localparam logic [CELL_W-1:0] LAST_ID = CELL_W'(CELLS - 1);
    localparam logic [ROW_W-1:0]  LAST_RC = ROW_W'(GRID_SIDE - 1);
    localparam logic [CLU_W-1:0]  MAX_C   = CLU_W'(MAX_CLUSTERS);

    // Sequencer and datapath registers.
    t_state                     r_state, n_state;
    logic [THR_W-1:0]           r_seed_thr, r_low_thr;
    logic [CELL_W:0]            r_load, n_load;
    logic [CELL_W-1:0]          r_clr, n_clr;
    logic [CELL_W-1:0]          r_scan_id, n_scan_id;
    logic [ROW_W-1:0]           r_scan_row, n_scan_row, r_scan_col, n_scan_col;
    logic [ROW_W-1:0]           r_cur_row, n_cur_row, r_cur_col, n_cur_col;
    logic [1:0]                 r_di, n_di, r_dj, n_dj;
    logic [CELL_W:0]            r_sp, n_sp;
    logic [SUM_W-1:0]           r_sum, n_sum;
    logic signed [MOM_W-1:0]    r_xm, n_xm, r_ym, n_ym;
    logic [CELL_W:0]            r_cnt, n_cnt;
    logic [CLU_W-1:0]           r_nclu, n_nclu, r_emit, n_emit;
    logic                       r_ovf, n_ovf;
    logic signed [POS_W-1:0]    r_xpos, n_xpos;
    t_cluster_out               r_out, n_out;
    logic                       r_out_valid, n_out_valid;

    // Memories and their registered read data.
    logic [ENERGY_BITS-1:0]     r_energy_mem [CELLS];
    logic                       r_visit_mem  [CELLS];
    logic [2*ROW_W-1:0]         r_stack_mem  [CELLS];
    t_cluster_out               r_buf_mem    [MAX_CLUSTERS];
    logic [ENERGY_BITS-1:0]     r_e_q;
    logic                       r_v_q;
    logic [2*ROW_W-1:0]         r_s_q;
    t_cluster_out               r_b_q;

    logic                       e_we, v_we, v_wdata, s_we, b_we;
    logic [CELL_W-1:0]          e_waddr, v_waddr, s_waddr, s_raddr, rd_addr;
    logic [ENERGY_BITS-1:0]     e_wdata;
    logic [2*ROW_W-1:0]         s_wdata;
    logic [BUF_W-1:0]           b_waddr, b_raddr;
    t_cluster_out               b_wdata;

    // Combinational helpers.
    logic                       in_beat, out_beat;
    logic [IN_E_W+ENERGY_BITS-1:0] e_ext_in;
    logic [CMP_W-1:0]           e_cmp, seed_cmp, low_cmp;
    logic [ROW_W-1:0]           nb_row, nb_col, s_row, s_col;
    logic [CELL_W-1:0]          nb_addr, pop_addr;
    logic                       nb_ok, nb_last;
    logic [CELL_W:0]            sp_m1;
    logic signed [COORD_W-1:0]  x_c, y_c;
    logic signed [COORD_W+ENERGY_BITS:0] x_prod, y_prod;
    logic [SUM_W+CLU_E_W-1:0]   sum_ext;
    logic [CELL_W+ID_W-1:0]     seed_ext;
    logic [CELL_W+ID_W:0]       cnt_ext;
    logic [CLU_W-1:0]           nclu_m1;
    logic                       div_start, div_done;
    logic signed [MOM_W-1:0]    div_moment;
    logic signed [POS_W-1:0]    div_pos;

    assign in_beat  = i_in_valid & o_in_ready;
    assign out_beat = r_out_valid & i_out_ready;
    assign e_ext_in = {{ENERGY_BITS{1'b0}}, i_in.crystal_energy};
    assign e_cmp    = CMP_W'(r_e_q);
    assign seed_cmp = CMP_W'(r_seed_thr);
    assign low_cmp  = CMP_W'(r_low_thr);
    assign sp_m1    = r_sp - 1'b1;
    assign nclu_m1  = r_nclu - 1'b1;

    // Neighbour coordinates and grid-edge test.
    assign nb_col  = ROW_W'({1'b0, r_cur_col} + (ROW_W + 1)'(r_di) - 1'b1);
    assign nb_row  = ROW_W'({1'b0, r_cur_row} + (ROW_W + 1)'(r_dj) - 1'b1);
    assign nb_ok   = !((r_di == 2'd0) && (r_cur_col == '0))
                   && !((r_di == 2'd2) && (r_cur_col == LAST_RC))
                   && !((r_dj == 2'd0) && (r_cur_row == '0))
                   && !((r_dj == 2'd2) && (r_cur_row == LAST_RC));
    assign nb_last = (r_di == 2'd2) && (r_dj == 2'd2);
    assign nb_addr = CELL_W'(nb_row * GRID_SIDE) + CELL_W'(nb_col);
    assign s_row   = r_s_q[2*ROW_W-1:ROW_W];
    assign s_col   = r_s_q[ROW_W-1:0];
    assign pop_addr = CELL_W'(s_row * GRID_SIDE) + CELL_W'(s_col);

    // Member coordinates and energy moments.
    assign x_c    = signed'({1'b0, r_cur_col}) - signed'(COORD_W'(HALF));
    assign y_c    = signed'({1'b0, r_cur_row}) - signed'(COORD_W'(HALF));
    assign x_prod = x_c * signed'({1'b0, r_e_q});
    assign y_prod = y_c * signed'({1'b0, r_e_q});

    // Output field width adaptation.
    assign sum_ext  = {{CLU_E_W{1'b0}}, r_sum};
    assign seed_ext = {{ID_W{1'b0}}, r_scan_id};
    assign cnt_ext  = {{ID_W{1'b0}}, r_cnt};

    assign div_moment = (r_state == S_DIV_X) ? r_ym : r_xm;

    ccf_divider #(
        .MOM_W (MOM_W),
        .SUM_W (SUM_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_moment (div_moment),
        .i_sum    (r_sum),
        .o_done   (div_done),
        .o_pos    (div_pos)
    );

    // Next state, memory controls and datapath updates.
    always_comb begin
        n_state     = r_state;
        n_load      = r_load;
        n_clr       = r_clr;
        n_scan_id   = r_scan_id;
        n_scan_row  = r_scan_row;
        n_scan_col  = r_scan_col;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_di        = r_di;
        n_dj        = r_dj;
        n_sp        = r_sp;
        n_sum       = r_sum;
        n_xm        = r_xm;
        n_ym        = r_ym;
        n_cnt       = r_cnt;
        n_nclu      = r_nclu;
        n_emit      = r_emit;
        n_ovf       = r_ovf;
        n_xpos      = r_xpos;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;
        e_we        = 1'b0;
        e_waddr     = r_load[CELL_W-1:0];
        e_wdata     = e_ext_in[ENERGY_BITS-1:0];
        v_we        = 1'b0;
        v_waddr     = nb_addr;
        v_wdata     = 1'b1;
        s_we        = 1'b0;
        s_waddr     = r_sp[CELL_W-1:0];
        s_wdata     = {nb_row, nb_col};
        s_raddr     = sp_m1[CELL_W-1:0];
        rd_addr     = nb_addr;
        b_we        = 1'b0;
        b_waddr     = r_nclu[BUF_W-1:0];
        b_raddr     = r_emit[BUF_W-1:0];
        b_wdata     = '0;
        div_start   = 1'b0;

        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (in_beat) begin
                    if (r_load < CELLS_C) begin
                        e_we   = 1'b1;
                        n_load = r_load + 1'b1;
                    end
                    if (i_in.frame_last) begin
                        n_load  = '0;
                        n_clr   = '0;
                        n_nclu  = '0;
                        n_ovf   = 1'b0;
                        n_state = S_CLEAR;
                    end
                end
            end

            // Clear the visited marks, one crystal a cycle.
            S_CLEAR: begin
                v_we    = 1'b1;
                v_waddr = r_clr;
                v_wdata = 1'b0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == LAST_ID) begin
                    n_scan_id  = '0;
                    n_scan_row = '0;
                    n_scan_col = '0;
                    n_state    = S_SCAN;
                end
            end

            S_SCAN: begin
                rd_addr = r_scan_id;
                n_state = S_SCAN_CHK;
            end

            // A free crystal above the seed threshold opens a cluster.
            S_SCAN_CHK: begin
                if (!r_v_q && (e_cmp > seed_cmp)) begin
                    v_we    = 1'b1;
                    v_waddr = r_scan_id;
                    s_we    = 1'b1;
                    s_waddr = '0;
                    s_wdata = {r_scan_row, r_scan_col};
                    n_sp    = (CELL_W + 1)'(1);
                    n_sum   = '0;
                    n_xm    = '0;
                    n_ym    = '0;
                    n_cnt   = '0;
                    n_state = S_POP;
                end else begin
                    n_state = S_NEXT;
                end
            end

            S_POP: begin
                if (r_sp == '0) begin
                    if (r_nclu == MAX_C) begin
                        n_ovf   = 1'b1;
                        n_state = S_NEXT;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV_X;
                    end
                end else begin
                    n_sp    = sp_m1;
                    n_state = S_POP_WAIT;
                end
            end

            S_POP_WAIT: begin
                n_cur_row = s_row;
                n_cur_col = s_col;
                rd_addr   = pop_addr;
                n_state   = S_ADD;
            end

            S_ADD: begin
                n_sum   = r_sum + SUM_W'(r_e_q);
                n_xm    = r_xm + MOM_W'(x_prod);
                n_ym    = r_ym + MOM_W'(y_prod);
                n_cnt   = r_cnt + 1'b1;
                n_di    = 2'd0;
                n_dj    = 2'd0;
                n_state = S_NB;
            end

            // Walk the 3x3 neighbourhood, column offset outermost.
            S_NB: begin
                if (nb_ok) begin
                    n_state = S_NB_CHK;
                end else if (nb_last) begin
                    n_state = S_POP;
                end else if (r_dj == 2'd2) begin
                    n_dj = 2'd0;
                    n_di = r_di + 1'b1;
                end else begin
                    n_dj = r_dj + 1'b1;
                end
            end

            S_NB_CHK: begin
                if (!r_v_q && (e_cmp > low_cmp)) begin
                    v_we = 1'b1;
                    if (r_sp < CELLS_C) begin
                        s_we = 1'b1;
                        n_sp = r_sp + 1'b1;
                    end
                end
                if (nb_last) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_NB;
                    if (r_dj == 2'd2) begin
                        n_dj = 2'd0;
                        n_di = r_di + 1'b1;
                    end else begin
                        n_dj = r_dj + 1'b1;
                    end
                end
            end

            S_DIV_X: begin
                if (div_done) begin
                    n_xpos    = div_pos;
                    div_start = 1'b1;
                    n_state   = S_DIV_Y;
                end
            end

            // Store the finished cluster in the result buffer.
            S_DIV_Y: begin
                if (div_done) begin
                    b_we                   = 1'b1;
                    b_wdata.cluster_valid  = 1'b1;
                    b_wdata.cluster_energy = sum_ext[CLU_E_W-1:0];
                    b_wdata.x_position     = r_xpos;
                    b_wdata.y_position     = div_pos;
                    b_wdata.seed_index     = seed_ext[ID_W-1:0];
                    b_wdata.member_total   = cnt_ext[ID_W-1:0];
                    n_nclu                 = r_nclu + 1'b1;
                    n_state                = S_NEXT;
                end
            end

            S_NEXT: begin
                if (r_scan_id == LAST_ID) begin
                    n_emit = '0;
                    if (r_nclu == '0) begin
                        n_state = S_EMPTY;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end else begin
                    n_scan_id = r_scan_id + 1'b1;
                    if (r_scan_col == LAST_RC) begin
                        n_scan_col = '0;
                        n_scan_row = r_scan_row + 1'b1;
                    end else begin
                        n_scan_col = r_scan_col + 1'b1;
                    end
                    n_state = S_SCAN;
                end
            end

            S_EMPTY: begin
                n_out             = '0;
                n_out.last_result = 1'b1;
                n_out_valid       = 1'b1;
                n_state           = S_EMIT_WT;
            end

            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end

            S_EMIT_LD: begin
                n_out               = r_b_q;
                n_out.overflow_flag = r_ovf;
                n_out.last_result   = (r_emit == nclu_m1);
                n_out_valid         = 1'b1;
                n_state             = S_EMIT_WT;
            end

            S_EMIT_WT: begin
                if (out_beat) begin
                    n_out_valid = 1'b0;
                    if (r_out.last_result) begin
                        n_state = S_LOAD;
                    end else begin
                        n_emit  = r_emit + 1'b1;
                        n_state = S_EMIT_RD;
                    end
                end
            end

            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_load      <= '0;
            r_sp        <= '0;
            r_sum       <= '0;
            r_xm        <= '0;
            r_ym        <= '0;
            r_nclu      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load      <= n_load;
            r_sp        <= n_sp;
            r_sum       <= n_sum;
            r_xm        <= n_xm;
            r_ym        <= n_ym;
            r_nclu      <= n_nclu;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_clr      <= n_clr;
        r_scan_id  <= n_scan_id;
        r_scan_row <= n_scan_row;
        r_scan_col <= n_scan_col;
        r_cur_row  <= n_cur_row;
        r_cur_col  <= n_cur_col;
        r_di       <= n_di;
        r_dj       <= n_dj;
        r_cnt      <= n_cnt;
        r_emit     <= n_emit;
        r_xpos     <= n_xpos;
        r_out      <= n_out;
    end

    // Threshold registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_thr <= THR_W'(800);
            r_low_thr  <= THR_W'(8);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SEED_THR: r_seed_thr <= i_cfg_data;
                REG_LOW_THR:  r_low_thr  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Energy store and visited marks share one read address.
    always_ff @(posedge i_clk) begin
        if (e_we) begin
            r_energy_mem[e_waddr] <= e_wdata;
        end
        r_e_q <= r_energy_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_visit_mem[v_waddr] <= v_wdata;
        end
        r_v_q <= r_visit_mem[rd_addr];
    end

    // Search stack of grid coordinates.
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_stack_mem[s_waddr] <= s_wdata;
        end
        r_s_q <= r_stack_mem[s_raddr];
    end

    // Result buffer, held until the overflow flag of the frame is known.
    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_buf_mem[b_waddr] <= b_wdata;
        end
        r_b_q <= r_buf_mem[b_raddr];
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The block never takes crystals while a result beat is pending.
    a_no_load_during_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !o_in_ready)
        else $error("input ready while a result beat is pending");

    // The search stack never grows past the grid.
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CELLS_C)
        else $error("search stack pointer out of range");

    // Buffered clusters never exceed the limit.
    a_cluster_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nclu <= MAX_C)
        else $error("cluster count past limit");

    // Taking the last beat of a frame returns the block to loading.
    a_last_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && r_out.last_result) |=> o_in_ready)
        else $error("block did not return to loading after last result");

endmodule

// ----- test/tb_calorimeter_cluster_finder_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calorimeter cluster finder testbench
// Feeds crystal frames under several threshold settings and idling patterns,
// and predicts every cluster of each frame with a flood fill of its own.
// Each result beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_calorimeter_cluster_finder_unit;
    import ccf_pkg::*;

    localparam int SIDE      = 35;
    localparam int HALF      = SIDE / 2;
    localparam int CELLS     = SIDE * SIDE;
    localparam int MAX_CLU   = 64;
    localparam int PITCH     = 80;
    localparam int WATCHDOG  = 300000;
    localparam int HOLD_LEN  = 3000;

    // Scoreboard: keeps a copy of the energy store and the thresholds, and
    // the clusters still owed by the block.
    class cluster_scoreboard;
        logic [THR_W-1:0]  seed_thr = 16'd800;
        logic [THR_W-1:0]  low_thr  = 16'd8;
        logic [IN_E_W-1:0] energy[CELLS];
        int                load_pos = 0;
        t_cluster_out      pending[$];
        int                errors   = 0;

        task report(string what, longint got, longint want);
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        // Rounded, saturated energy-weighted centroid in 1/16 mm.
        function longint centroid(longint moment, longint den);
            longint mag;
            longint q;
            bit     neg;
            if (den == 0) return 0;
            neg = moment < 0;
            mag = (neg ? -moment : moment) * PITCH;
            q = (2 * mag + den) / (2 * den);
            if (q > 2048) q = 2048;
            if (neg) return -q;
            return (q > 2047) ? 2047 : q;
        endfunction

        // Scan all crystals and flood fill every unclaimed seed.
        function void cluster_frame();
            bit           claimed[CELLS];
            int           stk[CELLS];
            int           sp, cur, cx, cy, nx, ny, nid, members, emitted;
            longint       sum, xm, ym;
            bit           dropped;
            t_cluster_out found[MAX_CLU];
            t_cluster_out r;
            emitted = 0;
            dropped = 0;
            foreach (claimed[i]) claimed[i] = 0;
            for (int id = 0; id < CELLS; id++) begin
                if (claimed[id] || energy[id] <= seed_thr) continue;
                sum = 0; xm = 0; ym = 0; members = 0;
                claimed[id] = 1;
                stk[0] = id;
                sp = 1;
                while (sp > 0) begin
                    sp--;
                    cur = stk[sp];
                    cx = cur % SIDE;
                    cy = cur / SIDE;
                    sum += energy[cur];
                    xm += longint'(cx - HALF) * longint'(energy[cur]);
                    ym += longint'(cy - HALF) * longint'(energy[cur]);
                    members++;
                    for (int dx = -1; dx <= 1; dx++) begin
                        for (int dy = -1; dy <= 1; dy++) begin
                            nx = cx + dx;
                            ny = cy + dy;
                            if (nx < 0 || ny < 0 || nx >= SIDE || ny >= SIDE) continue;
                            nid = ny * SIDE + nx;
                            if (claimed[nid] || energy[nid] <= low_thr) continue;
                            claimed[nid] = 1;
                            stk[sp] = nid;
                            sp++;
                        end
                    end
                end
                if (emitted >= MAX_CLU) begin
                    dropped = 1;
                    continue;
                end
                r = '0;
                r.cluster_valid  = 1'b1;
                r.cluster_energy = sum[CLU_E_W-1:0];
                r.x_position     = POS_W'(centroid(xm, sum));
                r.y_position     = POS_W'(centroid(ym, sum));
                r.seed_index     = ID_W'(id);
                r.member_total   = ID_W'(members);
                found[emitted] = r;
                emitted++;
            end
            if (emitted == 0) begin
                r = '0;
                r.last_result = 1'b1;
                pending.insert(pending.size(), r);
            end else begin
                for (int k = 0; k < emitted; k++) found[k].overflow_flag = dropped;
                found[emitted-1].last_result = 1'b1;
                for (int k = 0; k < emitted; k++) pending.insert(pending.size(), found[k]);
            end
        endfunction

        function void note_crystal(t_crystal_in c);
            if (load_pos < CELLS) begin
                energy[load_pos] = c.crystal_energy;
                load_pos++;
            end
            if (c.frame_last) begin
                load_pos = 0;
                cluster_frame();
            end
        endfunction

        task check_cluster(t_cluster_out got);
            t_cluster_out want;
            if (pending.size() == 0) begin
                report("unexpected beat, seed", got.seed_index, -1);
                return;
            end
            want = pending.pop_front();
            if (got.cluster_valid != want.cluster_valid)
                report("cluster_valid", got.cluster_valid, want.cluster_valid);
            if (got.cluster_energy != want.cluster_energy)
                report("cluster_energy", got.cluster_energy, want.cluster_energy);
            if (got.x_position != want.x_position)
                report("x_position", got.x_position, want.x_position);
            if (got.y_position != want.y_position)
                report("y_position", got.y_position, want.y_position);
            if (got.seed_index != want.seed_index)
                report("seed_index", got.seed_index, want.seed_index);
            if (got.member_total != want.member_total)
                report("member_total", got.member_total, want.member_total);
            if (got.overflow_flag != want.overflow_flag)
                report("overflow_flag", got.overflow_flag, want.overflow_flag);
            if (got.last_result != want.last_result)
                report("last_result", got.last_result, want.last_result);
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_crystal_in          i_in = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_cluster_out         o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_SEED_THR;
    logic [THR_W-1:0]     i_cfg_data = '0;

    cluster_scoreboard    sb;
    logic [IN_E_W-1:0]    frame_e[CELLS + 8];
    logic [THR_W-1:0]     seeds[5] = '{16'd800, 16'd0, 16'd65535, 16'd20000, 16'd5};
    logic [THR_W-1:0]     lows[5]  = '{16'd8, 16'd0, 16'd65535, 16'd1000, 16'd3};
    int                   idle_pct = 0;
    int                   stall_pct = 0;
    int                   hold_left = 0;
    bit                   hold_req = 0;
    bit                   crystal_taken = 0;
    bit                   reg_taken = 0;
    int                   quiet_cycles = 0;
    int                   random_items = 0;

    calorimeter_cluster_finder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Beat monitor: every handshake is seen at the rising edge.
    always @(posedge i_clk) begin
        crystal_taken <= i_in_valid && o_in_ready;
        reg_taken     <= i_cfg_valid && o_cfg_ready;
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_crystal(i_in);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_cluster(o_out);
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_SEED_THR) sb.seed_thr = i_cfg_data;
            else sb.low_thr = i_cfg_data;
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("tb_calorimeter_cluster_finder_unit NOT OK");
            $finish;
        end
    end

    // Result receiver: random stalls, plus a long hold-off when asked.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_LEN;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(negedge i_clk); while (!reg_taken);
        i_cfg_valid = 1'b0;
    endtask

    // Send the first len energies of frame_e, the last beat closing the frame.
    // Without sender idling the beats follow back to back.
    task automatic send_frame(int len);
        @(negedge i_clk);
        for (int i = 0; i < len; i++) begin
            while ($urandom_range(99) < idle_pct) begin
                i_in_valid = 1'b0;
                @(negedge i_clk);
            end
            i_in_valid = 1'b1;
            i_in.crystal_energy = frame_e[i];
            i_in.frame_last = (i == len - 1);
            do @(negedge i_clk); while (!crystal_taken);
        end
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() > 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic fill_const(logic [IN_E_W-1:0] v);
        foreach (frame_e[i]) frame_e[i] = v;
    endtask

    // Mostly quiet crystals with a few hot spots and some full-range values.
    task automatic fill_random(int len);
        int pick;
        int c;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (pick < 65) frame_e[i] = IN_E_W'($urandom_range(0, 40));
            else if (pick < 90) frame_e[i] = IN_E_W'($urandom_range(0, 4000));
            else frame_e[i] = IN_E_W'($urandom);
        end
        repeat ($urandom_range(0, 4)) begin
            c = $urandom_range(0, len - 1);
            frame_e[c] = IN_E_W'($urandom_range(1000, 65535));
            for (int d = -SIDE - 1; d <= SIDE + 1; d++)
                if (c + d >= 0 && c + d < len && $urandom_range(1))
                    frame_e[c + d] = IN_E_W'($urandom_range(9, 3000));
        end
    endtask

    initial begin
        int len;
        int mode;
        sb = new();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Full grid load with seeds in the corners and neighbours at or just above
        // the low threshold; the beats past the last crystal ID are dropped.
        fill_const(16'd0);
        frame_e[0] = 16'd1000; frame_e[1] = 16'd9; frame_e[SIDE + 1] = 16'd9;
        frame_e[SIDE - 1] = 16'd1000; frame_e[SIDE - 2] = 16'd9;
        frame_e[CELLS - SIDE] = 16'd801; frame_e[CELLS - 2 * SIDE] = 16'd8;
        frame_e[CELLS - 1] = 16'd65535; frame_e[CELLS - 2] = 16'd9;
        for (int i = CELLS; i < CELLS + 5; i++) frame_e[i] = 16'hFFFF;
        send_frame(CELLS + 5);
        wait_drained();

        // No crystal can pass the top seed threshold: the empty-frame beat
        // from a one-beat frame.
        write_reg(REG_SEED_THR, 16'hFFFF);
        frame_e[0] = 16'hFFFF;
        send_frame(1);
        wait_drained();
        write_reg(REG_SEED_THR, 16'd800);

        // Top rows at full scale: one large cluster there, while the rest of the grid keeps earlier energies.
        fill_const(16'hFFFF);
        send_frame(3 * SIDE);
        wait_drained();

        // Isolated seeds on a lattice: more clusters than the limit.
        fill_const(16'd0);
        for (int i = 0; i < 7 * SIDE; i++)
            if ((i % SIDE) % 2 == 0 && (i / SIDE) % 2 == 0) frame_e[i] = 16'd900;
        send_frame(7 * SIDE);
        wait_drained();

        // A seed that sits below the low threshold still counts as a member.
        write_reg(REG_SEED_THR, 16'd100);
        write_reg(REG_LOW_THR, 16'd500);
        fill_const(16'd0);
        frame_e[40] = 16'd200; frame_e[41] = 16'd300;
        frame_e[100] = 16'd5000; frame_e[101] = 16'd501; frame_e[135] = 16'd500;
        send_frame(4 * SIDE);
        wait_drained();
        write_reg(REG_SEED_THR, 16'd800);
        write_reg(REG_LOW_THR, 16'd8);

        // Random frames under each threshold setting and idling pattern.
        for (int ph = 0; ph < 10; ph++) begin
            mode = ph % 4;
            idle_pct  = (mode == 1) ? 47 : (mode == 3) ? 37 : 0;
            stall_pct = (mode == 2) ? 47 : (mode == 3) ? 37 : 0;
            write_reg(REG_SEED_THR, seeds[ph % 5]);
            write_reg(REG_LOW_THR, lows[ph % 5]);
            if (ph == 2) hold_req = 1;
            for (int n = 0; n < 20; n += len) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(31, 90)
                                               : $urandom_range(1, 30);
                fill_random(len);
                send_frame(len);
                random_items += len;
            end
            wait_drained();
        end

        idle_pct = 0;
        stall_pct = 0;
        repeat (200) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_calorimeter_cluster_finder_unit OK");
        end else begin
            $display("tb_calorimeter_cluster_finder_unit NOT OK");
        end
        $finish;
    end

endmodule
